// File: src/cylinder_overlap_separation_defines.svh
// assertion macros for the cylinder overlap separation block
`ifndef CYLINDER_OVERLAP_SEPARATION_DEFINES_SVH
`define CYLINDER_OVERLAP_SEPARATION_DEFINES_SVH

// implication checked at every rising clock edge outside reset
`define COS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication checked at every rising clock edge outside reset
`define COS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: src/cos_pkg.sv
// shared types and constants for the cylinder overlap separation block
`default_nettype none
package cos_pkg;
   localparam int unsigned IDX_W = 6;
   localparam int unsigned CNT_W = 7;
   localparam int unsigned PASS_W = 4;
   localparam logic [PASS_W-1:0] PASS_RESET = 4'd2;
   localparam logic [63:0] NEAR_DIST2 = 64'd4295;

   typedef enum logic [4:0] {
      ST_LOAD, ST_PAIR_INIT, ST_RD_I, ST_RD_J, ST_CAP_J, ST_VCHK, ST_SQ1, ST_SQ2,
      ST_SQ3, ST_CMP, ST_ROOT, ST_DIV, ST_APPLY, ST_WR_I, ST_WR_J, ST_NEXT,
      ST_OUT_RD, ST_OUT_CAP, ST_OUT_WAIT
   } state_type;

   typedef struct packed {
      logic store_we;     // write incoming request to next slot
      logic count_clr;
      logic pair_init;
      logic rd_i;
      logic rd_j;
      logic cap_i;
      logic cap_j;
      logic vchk;
      logic sq1;
      logic sq2;
      logic sq3;
      logic cmp;
      logic root_start;
      logic div_start;
      logic apply;
      logic wr_i;
      logic wr_j;
      logic next_pair;
      logic out_rd;
      logic out_cap;
      logic out_adv;
   } cmd_type;

   typedef struct packed {
      logic skip;         // pair needs no correction
      logic near;         // pair nearly coincides
      logic root_done;
      logic div_done;
      logic pass_end;     // last pair of last pass handled
      logic no_pass;      // nothing to resolve
      logic out_last;
      logic out_empty;
   } stat_type;
endpackage
`default_nettype wire

// File: src/cos_ctrl.sv
// controller state machine for the cylinder overlap separation block
`default_nettype none
module cos_ctrl (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   input  wire logic            req_last_body,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  wire logic            rsp_stall,
   input  wire cos_pkg::stat_type stat,
   output cos_pkg::cmd_type     cmd
);
   import cos_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_stall = (state_ff != ST_LOAD);
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD:      if (accept && req_last_body) state_in = ST_PAIR_INIT;
         ST_PAIR_INIT: state_in = ST_RD_I;
         ST_RD_I: begin
            if (stat.no_pass) state_in = ST_OUT_RD;
            else state_in = ST_RD_J;
         end
         ST_RD_J:      state_in = ST_CAP_J;
         ST_CAP_J:     state_in = ST_VCHK;
         ST_VCHK:      state_in = stat.skip ? ST_NEXT : ST_SQ1;
         ST_SQ1:       state_in = stat.skip ? ST_NEXT : ST_SQ2;
         ST_SQ2:       state_in = ST_SQ3;
         ST_SQ3:       state_in = ST_CMP;
         ST_CMP: begin
            if (stat.skip) state_in = ST_NEXT;
            else if (stat.near) state_in = ST_APPLY;
            else state_in = ST_ROOT;
         end
         ST_ROOT:      if (stat.root_done) state_in = ST_DIV;
         ST_DIV:       if (stat.div_done) state_in = ST_APPLY;
         ST_APPLY:     state_in = ST_WR_I;
         ST_WR_I:      state_in = ST_WR_J;
         ST_WR_J:      state_in = ST_NEXT;
         ST_NEXT:      state_in = stat.pass_end ? ST_OUT_RD : ST_RD_I;
         ST_OUT_RD: begin
            if (stat.out_empty) state_in = ST_LOAD;
            else state_in = ST_OUT_CAP;
         end
         ST_OUT_CAP:   state_in = ST_OUT_WAIT;
         ST_OUT_WAIT: begin
            if (!rsp_stall) state_in = stat.out_last ? ST_LOAD : ST_OUT_RD;
         end
         default:      state_in = ST_LOAD;
      endcase
   end

   always_comb begin
      cmd = '0;
      rsp_valid_in = rsp_valid_ff;
      case (state_ff)
         ST_LOAD:      cmd.store_we = accept;
         ST_PAIR_INIT: cmd.pair_init = 1'b1;
         ST_RD_I:      cmd.rd_i = 1'b1;
         ST_RD_J: begin
            cmd.cap_i = 1'b1;
            cmd.rd_j  = 1'b1;
         end
         ST_CAP_J:     cmd.cap_j = 1'b1;
         ST_VCHK:      cmd.vchk = 1'b1;
         ST_SQ1:       cmd.sq1 = 1'b1;
         ST_SQ2:       cmd.sq2 = 1'b1;
         ST_SQ3:       cmd.sq3 = 1'b1;
         ST_CMP: begin
            cmd.cmp = 1'b1;
            cmd.root_start = !stat.skip && !stat.near;
         end
         ST_ROOT:      cmd.div_start = stat.root_done;
         ST_DIV:       ;
         ST_APPLY:     cmd.apply = 1'b1;
         ST_WR_I:      cmd.wr_i = 1'b1;
         ST_WR_J:      cmd.wr_j = 1'b1;
         ST_NEXT:      cmd.next_pair = 1'b1;
         ST_OUT_RD: begin
            cmd.out_rd = 1'b1;
            cmd.count_clr = stat.out_empty;
         end
         ST_OUT_CAP: begin
            cmd.out_cap  = 1'b1;
            rsp_valid_in = 1'b1;
         end
         ST_OUT_WAIT: begin
            if (!rsp_stall) begin
               rsp_valid_in  = 1'b0;
               cmd.out_adv   = 1'b1;
               cmd.count_clr = stat.out_last;
            end
         end
         default:      ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule
`default_nettype wire

// File: src/cos_sqrt.sv
// iterative square root; a new start restarts it, dropping any root in progress
`default_nettype none
module cos_sqrt (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [63:0] radicand,
   output logic             done,
   output logic [31:0]      root
);
   import cos_pkg::*;

   logic [63:0] rem_ff, rem_in;
   logic [63:0] res_ff, res_in;
   logic [63:0] bit_ff, bit_in;
   logic        busy_ff, busy_in;
   logic [63:0] trial;

   assign trial = res_ff + bit_ff;
   assign done  = busy_ff && (bit_ff == 64'd0);
   assign root  = res_ff[31:0];

   always_comb begin
      rem_in  = rem_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = radicand;
         res_in  = '0;
         bit_in  = 64'h4000_0000_0000_0000;
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         // skipping leading zero pairs is equivalent to subtract-free steps
         if (rem_ff >= trial) begin
            rem_in = rem_ff - trial;
            res_in = (res_ff >> 1) + bit_ff;
         end else begin
            res_in = res_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      rem_ff <= rem_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
   end
endmodule
`default_nettype wire

// File: src/cos_div.sv
// restoring divider, two quotients with a shared divisor, one bit per cycle
`default_nettype none
module cos_div (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic [53:0] num_a,
   input  wire logic [53:0] num_b,
   input  wire logic [33:0] divisor,
   output logic             done,
   output logic [53:0]      quo_a,
   output logic [53:0]      quo_b
);
   import cos_pkg::*;

   logic [53:0] qa_ff, qa_in, qb_ff, qb_in;
   logic [34:0] ra_ff, ra_in, rb_ff, rb_in;
   logic [33:0] dv_ff, dv_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic [34:0] ta, tb;

   assign done  = busy_ff && (cnt_ff == 6'd0);
   assign quo_a = qa_ff;
   assign quo_b = qb_ff;
   assign ta = {ra_ff[33:0], qa_ff[53]};
   assign tb = {rb_ff[33:0], qb_ff[53]};

   always_comb begin
      qa_in = qa_ff; qb_in = qb_ff; ra_in = ra_ff; rb_in = rb_ff;
      dv_in = dv_ff; cnt_in = cnt_ff; busy_in = busy_ff;
      if (start) begin
         qa_in = num_a; qb_in = num_b; ra_in = '0; rb_in = '0;
         dv_in = divisor; cnt_in = 6'd54; busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end else if (busy_ff) begin
         if (ta >= {1'b0, dv_ff}) begin
            ra_in = ta - {1'b0, dv_ff};
            qa_in = {qa_ff[52:0], 1'b1};
         end else begin
            ra_in = ta;
            qa_in = {qa_ff[52:0], 1'b0};
         end
         if (tb >= {1'b0, dv_ff}) begin
            rb_in = tb - {1'b0, dv_ff};
            qb_in = {qb_ff[52:0], 1'b1};
         end else begin
            rb_in = tb;
            qb_in = {qb_ff[52:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) busy_ff <= 1'b0;
      else busy_ff <= busy_in;
      qa_ff <= qa_in; qb_ff <= qb_in; ra_ff <= ra_in; rb_ff <= rb_in;
      dv_ff <= dv_in; cnt_ff <= cnt_in;
   end
endmodule
`default_nettype wire

// File: src/cos_datapath.sv
// body store, pair arithmetic and result registers
`default_nettype none
module cos_datapath #(
   parameter int unsigned MAX_BODIES = 64
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cos_pkg::cmd_type          cmd,
   output cos_pkg::stat_type              stat,
   input  wire logic [cos_pkg::PASS_W-1:0] pass_count,
   input  wire logic signed [31:0]        req_body_x,
   input  wire logic signed [31:0]        req_body_y,
   input  wire logic signed [31:0]        req_body_z,
   input  wire logic [19:0]               req_body_radius,
   input  wire logic [19:0]               req_body_height,
   output logic [cos_pkg::IDX_W-1:0]      rsp_body_index,
   output logic signed [31:0]             rsp_out_x,
   output logic signed [31:0]             rsp_out_y,
   output logic signed [31:0]             rsp_out_z,
   output logic                           rsp_last_result
);
   import cos_pkg::*;

   localparam int unsigned AW = (MAX_BODIES > 1) ? $clog2(MAX_BODIES) : 1;
   localparam logic [CNT_W-1:0] MAXC = CNT_W'(MAX_BODIES);

   // one word per body: x, y, z, radius, height
   logic [135:0] mem [MAX_BODIES];
   logic [135:0] rd_ff;
   logic [AW-1:0] rd_addr, wr_addr;
   logic [135:0] wr_data;
   logic          we;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] i_ff, i_in, j_ff, j_in;
   logic [PASS_W-1:0] pass_ff, pass_in;

   logic signed [31:0] xi_ff, zi_ff, xj_ff, zj_ff, yi_ff, yj_ff;
   logic [19:0] ri_ff, hi_ff, rj_ff, hj_ff;
   logic [135:0] wi_ff;
   logic signed [32:0] dx_ff, dz_ff;
   logic [32:0] adx_ff, adz_ff;
   logic [20:0] sum_ff;
   logic [41:0] sqx_ff, sqz_ff, sqs_ff;
   logic [63:0] d2_ff;
   logic signed [33:0] cx_ff, cz_ff;
   logic [42:0] ma_ff, mb_ff;
   logic [31:0] root;
   logic [53:0] qa, qb;
   logic        root_done, div_done;
   logic [33:0] ovl;

   logic signed [33:0] top_i, top_j;
   logic signed [32:0] dx_w, dz_w;
   logic [32:0] adx_w, adz_w;
   logic        vskip, hskip, d2skip;

   function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
      if (v > 35'sd2147483647) return 32'sh7fff_ffff;
      if (v < -35'sd2147483648) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // pair walk and body count
   always_comb begin
      count_in = count_ff;
      i_in = i_ff; j_in = j_ff; pass_in = pass_ff;
      if (cmd.store_we && count_ff < MAXC) count_in = count_ff + 1'b1;
      if (cmd.count_clr) count_in = '0;
      if (cmd.pair_init) begin
         i_in = '0; j_in = CNT_W'(1); pass_in = '0;
      end
      if (cmd.next_pair) begin
         if (j_ff + 1'b1 < count_ff) begin
            j_in = j_ff + 1'b1;
         end else if (i_ff + CNT_W'(2) < count_ff) begin
            i_in = i_ff + 1'b1; j_in = i_ff + CNT_W'(2);
         end else begin
            i_in = '0; j_in = CNT_W'(1); pass_in = pass_ff + 1'b1;
         end
      end
      if (cmd.out_rd && pass_ff != '1) begin
         // reuse i as the output walker once passes finish
      end
      if (cmd.out_adv) i_in = i_ff + 1'b1;
      if (cmd.count_clr) i_in = '0;
   end

   always_comb begin
      stat.no_pass   = (pass_count == '0) || (count_ff < CNT_W'(2));
      stat.pass_end  = cmd.next_pair && !(j_ff + 1'b1 < count_ff)
                       && !(i_ff + CNT_W'(2) < count_ff)
                       && (pass_ff + 1'b1 == pass_count);
      stat.out_empty = (i_ff >= count_ff);
      stat.out_last  = (i_ff + 1'b1 == count_ff);
      stat.root_done = root_done;
      stat.div_done  = div_done;
      stat.near      = (d2_ff < NEAR_DIST2);
      stat.skip      = vskip || hskip || d2skip;
   end

   // output walk restarts at zero: i is cleared by pair init and in the pair pass wrap
   always_comb begin
      rd_addr = i_ff[AW-1:0];
      if (cmd.rd_j) rd_addr = j_ff[AW-1:0];
      we = 1'b0; wr_addr = count_ff[AW-1:0];
      wr_data = {req_body_x, req_body_y, req_body_z, req_body_radius, req_body_height};
      if (cmd.store_we && count_ff < MAXC) we = 1'b1;
      if (cmd.wr_i) begin
         we = 1'b1; wr_addr = i_ff[AW-1:0];
         wr_data = {xi_ff, yi_ff, zi_ff, ri_ff, hi_ff};
      end
      if (cmd.wr_j) begin
         we = 1'b1; wr_addr = j_ff[AW-1:0];
         wr_data = {xj_ff, yj_ff, zj_ff, rj_ff, hj_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (we) mem[wr_addr] <= wr_data;
      rd_ff <= mem[rd_addr];
   end

   assign top_i = 34'(yi_ff) + 34'(hi_ff);
   assign top_j = 34'(yj_ff) + 34'(hj_ff);
   assign dx_w  = 33'(xj_ff) - 33'(xi_ff);
   assign dz_w  = 33'(zj_ff) - 33'(zi_ff);
   assign adx_w = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
   assign adz_w = dz_w[32] ? 33'(-dz_w) : 33'(dz_w);
   assign vskip = cmd.vchk && ((top_i <= 34'(yj_ff)) || (top_j <= 34'(yi_ff)));
   assign hskip = cmd.sq1 && ((adx_ff >= 33'(sum_ff)) || (adz_ff >= 33'(sum_ff)));
   assign d2skip = cmd.cmp && (d2_ff >= 64'(sqs_ff));
   assign ovl   = 34'(sum_ff) - 34'(root);

   always_ff @(posedge clock) begin
      if (cmd.cap_i) wi_ff <= rd_ff;
      if (cmd.cap_j) begin
         {xi_ff, yi_ff, zi_ff, ri_ff, hi_ff} <= wi_ff;
         {xj_ff, yj_ff, zj_ff, rj_ff, hj_ff} <= rd_ff;
      end
      if (cmd.vchk) begin
         dx_ff  <= dx_w;
         dz_ff  <= dz_w;
         adx_ff <= adx_w;
         adz_ff <= adz_w;
         sum_ff <= 21'(ri_ff) + 21'(rj_ff);
      end
      // magnitudes are below sum here, so 21 bits hold them
      if (cmd.sq2) begin
         sqx_ff <= 42'(adx_ff[20:0]) * 42'(adx_ff[20:0]);
         sqz_ff <= 42'(adz_ff[20:0]) * 42'(adz_ff[20:0]);
         sqs_ff <= 42'(sum_ff) * 42'(sum_ff);
      end
      if (cmd.sq3) d2_ff <= 64'(sqx_ff) + 64'(sqz_ff);
      if (cmd.cmp && d2_ff < NEAR_DIST2) begin
         cx_ff <= 34'(sum_ff >> 1);
         cz_ff <= '0;
      end
      if (cmd.div_start) begin
         ma_ff <= 43'(adx_ff[20:0]) * 43'(ovl[21:0]);
         mb_ff <= 43'(adz_ff[20:0]) * 43'(ovl[21:0]);
      end
      if (div_done) begin
         cx_ff <= dx_ff[32] ? -34'(qa[33:0]) : 34'(qa[33:0]);
         cz_ff <= dz_ff[32] ? -34'(qb[33:0]) : 34'(qb[33:0]);
      end
      if (cmd.apply) begin
         xi_ff <= sat32(35'(xi_ff) - 35'(cx_ff));
         zi_ff <= sat32(35'(zi_ff) - 35'(cz_ff));
         xj_ff <= sat32(35'(xj_ff) + 35'(cx_ff));
         zj_ff <= sat32(35'(zj_ff) + 35'(cz_ff));
      end
      if (cmd.out_cap) begin
         rsp_body_index  <= i_ff[IDX_W-1:0];
         {rsp_out_x, rsp_out_y, rsp_out_z} <= rd_ff[135:40];
         rsp_last_result <= (i_ff + 1'b1 == count_ff);
      end
   end

   // multiply needs a registered stage before division starts
   logic div_go_ff;
   logic [33:0] dist2x_ff;
   always_ff @(posedge clock) begin
      if (reset) div_go_ff <= 1'b0;
      else div_go_ff <= cmd.div_start;
      if (cmd.div_start) dist2x_ff <= {1'b0, root, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; i_ff <= '0; j_ff <= '0; pass_ff <= '0;
      end else begin
         count_ff <= count_in; i_ff <= i_in; j_ff <= j_in; pass_ff <= pass_in;
      end
   end

   cos_sqrt u_sqrt (
      .clock(clock), .reset(reset), .start(cmd.root_start), .radicand(d2_ff),
      .done(root_done), .root(root)
   );

   cos_div u_div (
      .clock(clock), .reset(reset), .start(div_go_ff), .num_a(54'(ma_ff)),
      .num_b(54'(mb_ff)), .divisor(dist2x_ff), .done(div_done), .quo_a(qa), .quo_b(qb)
   );
endmodule
`default_nettype wire

// File: src/cylinder_overlap_separation.sv
// top level of the cylinder overlap separation block
//  channel | direction | ports
//  req     | in        | req_valid, req_stall, req_body_*, req_last_body
//  rsp     | out       | rsp_valid, rsp_stall, rsp_body_index, rsp_out_*, rsp_last_result
//  csr     | in        | csr_write, csr_wdata (pass count)
// loading stores each accepted request in the next free slot; in resolution a pair is
// skipped after a failed span or distance check, applied without square root or divide
// when nearly coincident, or corrected after a square root and then a divide
// each result is read, captured and held until taken; rsp_stall holds the result register
// requests are stalled from the last body until every result has gone
// synchronous reset clears the body count and control; the store needs no clearing
`default_nettype none
`include "cylinder_overlap_separation_defines.svh"
module cylinder_overlap_separation #(
   parameter int unsigned MAX_BODIES = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic signed [31:0] req_body_x,
   input  wire logic signed [31:0] req_body_y,
   input  wire logic signed [31:0] req_body_z,
   input  wire logic [19:0]        req_body_radius,
   input  wire logic [19:0]        req_body_height,
   input  wire logic               req_last_body,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [5:0]              rsp_body_index,
   output logic signed [31:0]      rsp_out_x,
   output logic signed [31:0]      rsp_out_y,
   output logic signed [31:0]      rsp_out_z,
   output logic                    rsp_last_result,
   input  wire logic               csr_write,
   input  wire logic [3:0]         csr_wdata
);
   import cos_pkg::*;

   logic [PASS_W-1:0] pass_ff;
   cmd_type  cmd;
   stat_type stat;

   always_ff @(posedge clock) begin
      if (reset) pass_ff <= PASS_RESET;
      else if (csr_write) pass_ff <= csr_wdata;
   end

   cos_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_last_body(req_last_body),
      .req_stall(req_stall), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .cmd(cmd)
   );

   cos_datapath #(.MAX_BODIES(MAX_BODIES)) u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat), .pass_count(pass_ff),
      .req_body_x(req_body_x), .req_body_y(req_body_y), .req_body_z(req_body_z),
      .req_body_radius(req_body_radius), .req_body_height(req_body_height),
      .rsp_body_index(rsp_body_index), .rsp_out_x(rsp_out_x), .rsp_out_y(rsp_out_y),
      .rsp_out_z(rsp_out_z), .rsp_last_result(rsp_last_result)
   );

   `COS_ASSERT_IMPL(a_no_req_during_rsp, clock, reset, rsp_valid, req_stall, "req open")
   `COS_ASSERT_NEXT(a_rsp_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid, "rsp lost")
   `COS_ASSERT_IMPL(a_single_write, clock, reset, cmd.wr_i, !cmd.store_we, "store clash")
endmodule
`default_nettype wire

// File: dv/cylinder_overlap_separation_tb.sv
// self-checking testbench for the cylinder overlap separation block
`timescale 1ns / 100ps
`default_nettype none

class separation_scoreboard;
   typedef struct packed {
      logic [5:0]  index;
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic        last;
   } body_result_type;

   logic signed [31:0] pos_x [64];
   logic signed [31:0] pos_y [64];
   logic signed [31:0] pos_z [64];
   logic [19:0]        radius [64];
   logic [19:0]        height [64];
   int unsigned        count;
   logic [3:0]         passes;
   body_result_type    pending [$];
   int unsigned        mismatches;
   int unsigned        results_seen;
   int unsigned        sets_done;

   function new();
      count = 0;
      passes = cos_pkg::PASS_RESET;
      mismatches = 0;
      results_seen = 0;
      sets_done = 0;
   endfunction

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   function automatic longint unsigned root64(longint unsigned v);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v = v - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic longint push_share(longint d, longint unsigned ov,
                                         longint unsigned span);
      longint unsigned mag;
      longint unsigned c;
      mag = (d < 0) ? -d : d;
      c = (mag * ov) / (2 * span);
      return (d < 0) ? -longint'(c) : longint'(c);
   endfunction

   function automatic void separate(int i, int j);
      longint ti, tj, dx, dz, cx, cz;
      longint unsigned sum, adx, adz, d2, span;
      ti = longint'(pos_y[i]) + longint'({44'd0, height[i]});
      tj = longint'(pos_y[j]) + longint'({44'd0, height[j]});
      if (ti <= longint'(pos_y[j]) || tj <= longint'(pos_y[i])) return;
      sum = {44'd0, radius[i]} + {44'd0, radius[j]};
      dx = longint'(pos_x[j]) - longint'(pos_x[i]);
      dz = longint'(pos_z[j]) - longint'(pos_z[i]);
      adx = (dx < 0) ? -dx : dx;
      adz = (dz < 0) ? -dz : dz;
      if (adx >= sum || adz >= sum) return;
      d2 = adx * adx + adz * adz;
      if (d2 >= sum * sum) return;
      if (d2 < cos_pkg::NEAR_DIST2) begin
         cx = sum >> 1;
         cz = 0;
      end else begin
         span = root64(d2);
         cx = push_share(dx, sum - span, span);
         cz = push_share(dz, sum - span, span);
      end
      pos_x[i] = clamp32(longint'(pos_x[i]) - cx);
      pos_z[i] = clamp32(longint'(pos_z[i]) - cz);
      pos_x[j] = clamp32(longint'(pos_x[j]) + cx);
      pos_z[j] = clamp32(longint'(pos_z[j]) + cz);
   endfunction

   function void note_request(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [19:0] r, logic [19:0] h, logic last);
      body_result_type e;
      if (count < 64) begin
         pos_x[count] = x;
         pos_y[count] = y;
         pos_z[count] = z;
         radius[count] = r;
         height[count] = h;
         count++;
      end
      if (!last) return;
      for (int p = 0; p < passes; p++)
         for (int i = 0; i < count; i++)
            for (int j = i + 1; j < count; j++)
               separate(i, j);
      for (int i = 0; i < count; i++) begin
         e.index = i[5:0];
         e.x = pos_x[i];
         e.y = pos_y[i];
         e.z = pos_z[i];
         e.last = (i + 1 == count);
         pending = {pending, e};
      end
      count = 0;
      sets_done++;
   endfunction

   function void check_result(body_result_type got);
      body_result_type e;
      results_seen++;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result %p", got);
         return;
      end
      e = pending.pop_front();
      if (got != e) begin
         mismatches++;
         if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
   endfunction
endclass

module cylinder_overlap_separation_tb;
   import cos_pkg::*;

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [31:0] z;
      logic [19:0] r;
      logic [19:0] h;
      logic        last;
   } body_req_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [31:0] req_body_x = '0, req_body_y = '0, req_body_z = '0;
   logic [19:0] req_body_radius = '0, req_body_height = '0;
   logic req_last_body = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [5:0] rsp_body_index;
   logic signed [31:0] rsp_out_x, rsp_out_y, rsp_out_z;
   logic rsp_last_result;
   logic csr_write = 1'b0;
   logic [3:0] csr_wdata = '0;

   separation_scoreboard board = new();
   body_req_type items [$];
   longint unsigned cycles = 0;
   bit long_hold = 1'b0;

   always #2 clock = ~clock;

   cylinder_overlap_separation dut (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > 64'd40000000) begin
         $display("timeout after %0d cycles", cycles);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // request and result acceptance, sampled at the edge
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         board.note_request(req_body_x, req_body_y, req_body_z, req_body_radius,
                            req_body_height, req_last_body);
      if (!reset && rsp_valid && !rsp_stall)
         board.check_result({rsp_body_index, rsp_out_x, rsp_out_y, rsp_out_z,
                             rsp_last_result});
   end

   // receiver stall pattern with one long hold-off
   initial begin
      int mode;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (long_hold) rsp_stall <= 1'b1;
         else begin
            mode = (cycles / 300) % 3;
            if (mode == 0) rsp_stall <= 1'b0;
            else if (mode == 1) rsp_stall <= ($urandom_range(0, 3) == 0);
            else rsp_stall <= ($urandom_range(0, 1) == 0);
         end
      end
   end

   function automatic void add_item(body_req_type b);
      items = {items, b};
   endfunction

   task automatic write_passes(logic [3:0] v);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
      board.passes = v;
   endtask

   // one edge first so the last accepted request is noted before the wait
   task automatic drain();
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // offer the queued requests, in bursts with gaps between them when gaps is set
   task automatic send_items(bit gaps);
      body_req_type b;
      int burst;
      burst = $urandom_range(1, 12);
      while (items.size() != 0) begin
         b = items.pop_front();
         req_valid <= 1'b1;
         {req_body_x, req_body_y, req_body_z, req_body_radius, req_body_height,
          req_last_body} <= b;
         @(posedge clock);
         while (req_stall) @(posedge clock);
         burst--;
         if (gaps && burst == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst = $urandom_range(1, 12);
         end
      end
      req_valid <= 1'b0;
   endtask

   function automatic body_req_type rand_body(int spread, bit last);
      body_req_type b;
      b.x = $signed($urandom_range(0, 2 * spread)) - spread;
      b.y = $signed($urandom_range(0, 2 * spread)) - spread;
      b.z = $signed($urandom_range(0, 2 * spread)) - spread;
      b.r = $urandom_range(1, 20'hfffff);
      b.h = $urandom_range(1, 20'hfffff);
      b.last = last;
      return b;
   endfunction

   // one well-formed set of n cylinders placed within the given spread of the origin
   task automatic queue_set(int n, int spread);
      for (int k = 0; k < n; k++) add_item(rand_body(spread, k == n - 1));
   endtask

   initial begin
      int n;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, coincident bodies, disjoint spans, saturation, near miss
      add_item({32'sh7fffff00, 32'sd0, 32'sh80000100, 20'hfffff, 20'hfffff, 1'b0});
      add_item({32'sh7fffff00, 32'sd0, 32'sh80000100, 20'hfffff, 20'hfffff, 1'b1});
      add_item({32'sh80000000, 32'sh80000000, 32'sh7fffffff, 20'd1, 20'd1, 1'b0});
      add_item({32'sh80000000, 32'sh7fff0000, 32'sh7fffffff, 20'd1, 20'd1, 1'b1});
      add_item({32'sd0, 32'sd0, 32'sd0, 20'h10000, 20'h10000, 1'b0});
      add_item({32'sd1, 32'sd0, -32'sd1, 20'h10000, 20'h10000, 1'b0});
      add_item({32'sd0, 32'sh10000, 32'sd0, 20'h10000, 20'h10000, 1'b0});
      add_item({32'sh20000, 32'sd5, 32'sd0, 20'h10000, 20'h08000, 1'b1});
      add_item({32'sd0, 32'sd0, 32'sd0, 20'h10000, 20'h10000, 1'b1});
      send_items(1'b0);
      drain();
      write_passes(4'd0);
      queue_set(3, 20000);
      send_items(1'b0);
      drain();
      write_passes(4'd15);
      queue_set(4, 40000);
      send_items(1'b1);
      drain();
      write_passes(4'd1);

      // overfill: 66 bodies, the extras are dropped
      for (int k = 0; k < 66; k++) add_item(rand_body(1 << 30, k == 65));
      send_items(1'b1);
      drain();

      // random sets, varying pass count between them
      for (int s = 0; s < 80; s++) begin
         if (s % 10 == 0) begin
            write_passes(4'($urandom_range(1, 8)));
         end
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
         if ($urandom_range(0, 4) == 0) queue_set(n, 32'h7fffffff);
         else queue_set(n, $urandom_range(1 << 10, 1 << 20));
         if (s == 40) begin
            long_hold = 1'b1;
            fork
               begin
                  repeat (3000) @(posedge clock);
                  long_hold = 1'b0;
               end
               begin
                  queue_set(5, 1 << 18);
                  send_items(1'b0);
               end
            join
         end
         send_items(1'b1);
         if (s % 10 == 9) drain();
      end
      write_passes(4'd8);
      queue_set(6, 1 << 16);
      send_items(1'b1);
      drain();
      repeat (200) @(posedge clock);

      $display("covered %0d sets and %0d results over pass counts 0 to 15",
               board.sets_done, board.results_seen);
      if (board.mismatches == 0 && board.pending.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d results missing", board.mismatches,
                  board.pending.size());
         $display("end of test: mismatches");
      end
      $finish;
   end
endmodule

`default_nettype wire
